/* hdl/kld_pkg.sv */
package kld_pkg;

    localparam int MaxRefEntries = 16;
    localparam int KeyBits       = 8;
    localparam int LevelBits     = 16;
    localparam int CntW          = $clog2(MaxRefEntries + 1);
    // partial sum of one probe over all cells, no overflow possible
    localparam int PsumW         = LevelBits + CntW;
    localparam int AccW          = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_PROBE  = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 matched;
        logic [KeyBits-1:0]   key;
        logic [LevelBits-1:0] level;
        logic [PsumW-1:0]     psum;
    } t_token;

endpackage

/* hdl/keyed_level_distance_top.sv */
// channel  | handshake          | payload
// request  | start / busy       | i_cmd, i_room_key, i_level, i_last
// result   | o_valid (strobe)   | o_distance, o_saturated, o_ref_overflow
//
// clear and append leave busy low.
// a probe walks the row of cells, one cell a cycle: busy stays high from the accepting edge
// until the probe leaves the last cell of the row.
// the result strobe is high in the first cycle that busy is low again after a last probe.
// synchronous active-low reset clears count, drop and saturation flags, accumulator, busy, strobe and row valid bits.
// results cannot be held off: o_valid is high for exactly one cycle.
module keyed_level_distance_top
    import kld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [KeyBits-1:0]   i_room_key,
    input  logic [LevelBits-1:0] i_level,
    input  logic                 i_last,
    output logic                 o_valid,
    output logic [AccW-1:0]      o_distance,
    output logic                 o_saturated,
    output logic                 o_ref_overflow
);

    logic              w_acc_req;
    logic [CntW-1:0]   r_count;
    logic              r_drop;
    logic              r_busy;
    logic [AccW-1:0]   r_acc;
    logic              r_sat;
    logic              r_valid;
    logic [AccW-1:0]   r_distance;
    logic              r_saturated;
    logic              r_overflow;
    t_token            w_tok [0:MaxRefEntries];
    t_token            w_tail;
    logic [AccW:0]     w_sum;
    logic [AccW-1:0]   w_acc_next;
    logic              w_clip;

    assign w_acc_req = start && !r_busy;
    assign busy      = r_busy;

    always_comb begin
        w_tok[0].valid   = w_acc_req && (i_cmd == CMD_PROBE);
        w_tok[0].last    = i_last;
        w_tok[0].matched = 1'b0;
        w_tok[0].key     = i_room_key;
        w_tok[0].level   = i_level;
        w_tok[0].psum    = '0;
    end

    for (genvar g = 0; g < MaxRefEntries; g++) begin : g_cell
        kld_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (w_acc_req && (i_cmd == CMD_APPEND) && (r_count == CntW'(g))),
            .i_wr_key   (i_room_key),
            .i_wr_level (i_level),
            .i_en       (r_count > CntW'(g)),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[MaxRefEntries];

    // no match anywhere: the probe level itself is added
    assign w_sum      = {1'b0, r_acc}
                      + (w_tail.matched ? (AccW+1)'(w_tail.psum) : (AccW+1)'(w_tail.level));
    assign w_clip     = w_sum[AccW];
    assign w_acc_next = w_clip ? {AccW{1'b1}} : w_sum[AccW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_busy  <= 1'b0;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_tail.valid && w_tail.last;
            if (w_acc_req) begin
                case (i_cmd)
                    CMD_CLEAR: begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                    end
                    CMD_APPEND: begin
                        if (r_count == CntW'(MaxRefEntries)) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + CntW'(1);
                        end
                    end
                    CMD_PROBE: begin
                        r_busy <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_tail.valid) begin
                r_busy <= 1'b0;
                if (w_tail.last) begin
                    r_acc   <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_acc   <= w_acc_next;
                    r_sat   <= r_sat | w_clip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid && w_tail.last) begin
            r_distance  <= w_acc_next;
            r_saturated <= r_sat | w_clip;
            r_overflow  <= r_drop;
        end
    end

    assign o_valid        = r_valid;
    assign o_distance     = r_distance;
    assign o_saturated    = r_saturated;
    assign o_ref_overflow = r_overflow;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxRefEntries))
        else $error("reference count beyond capacity");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> r_busy)
        else $error("probe leaves the row while idle");

    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_req && (i_cmd == CMD_PROBE)) |=> r_busy)
        else $error("probe accepted without going busy");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && $past(i_rst_n)) |-> ($past(w_tail.valid) && $past(w_tail.last)))
        else $error("result strobe without a last probe");

endmodule

/* hdl/kld_cell.sv */
module kld_cell
    import kld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [KeyBits-1:0]   i_wr_key,
    input  logic [LevelBits-1:0] i_wr_level,
    input  logic                 i_en,
    input  t_token               i_tok,
    output t_token               o_tok
);

    logic [KeyBits-1:0]   r_key;
    logic [LevelBits-1:0] r_level;
    t_token               r_tok;
    t_token               n_tok;
    logic                 w_hit;
    logic [LevelBits-1:0] w_diff;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_key   <= i_wr_key;
            r_level <= i_wr_level;
        end
    end

    assign w_hit  = i_tok.valid && i_en && (i_tok.key == r_key);
    assign w_diff = (i_tok.level >= r_level) ? (i_tok.level - r_level)
                                             : (r_level - i_tok.level);

    always_comb begin
        n_tok         = i_tok;
        n_tok.matched = i_tok.matched | w_hit;
        n_tok.psum    = i_tok.psum + (w_hit ? PsumW'(w_diff) : PsumW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.last    <= n_tok.last;
        r_tok.matched <= n_tok.matched;
        r_tok.key     <= n_tok.key;
        r_tok.level   <= n_tok.level;
        r_tok.psum    <= n_tok.psum;
    end

    assign o_tok = r_tok;

endmodule

/* verif/tb_keyed_level_distance_top.sv */
module tb_keyed_level_distance_top;
    import kld_pkg::*;

    localparam logic [1:0] CmdUnused  = 2'd3;
    localparam int         CycleLimit = 1000000;
    localparam int         DrainWait  = 2 * MaxRefEntries + 8;

    typedef struct packed {
        logic [AccW-1:0] distance;
        logic            saturated;
        logic            ref_overflow;
    } t_dist_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_cmd;
    logic [KeyBits-1:0]   i_room_key;
    logic [LevelBits-1:0] i_level;
    logic                 i_last;
    logic                 o_valid;
    logic [AccW-1:0]      o_distance;
    logic                 o_saturated;
    logic                 o_ref_overflow;

    // predictor state
    logic [KeyBits-1:0]   stored_keys   [MaxRefEntries];
    logic [LevelBits-1:0] stored_levels [MaxRefEntries];
    int                   stored_count = 0;
    logic [AccW-1:0]      running_sum  = '0;
    logic                 sum_clipped  = 1'b0;
    logic                 drop_seen    = 1'b0;

    t_dist_result pending_sums[$];
    int           err_count = 0;
    int           cycle_count = 0;
    int           idle_pct = 0;

    keyed_level_distance_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_room_key     (i_room_key),
        .i_level        (i_level),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_distance     (o_distance),
        .o_saturated    (o_saturated),
        .o_ref_overflow (o_ref_overflow)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic void predict_request(input logic [1:0] cmd,
                                            input logic [KeyBits-1:0] key,
                                            input logic [LevelBits-1:0] lvl,
                                            input logic last);
        longint       add;
        longint       total;
        longint       a;
        longint       b;
        logic         hit;
        t_dist_result res;
        add = 0;
        hit = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                stored_count = 0;
                drop_seen    = 1'b0;
            end
            CMD_APPEND: begin
                if (stored_count < MaxRefEntries) begin
                    stored_keys[stored_count]   = key;
                    stored_levels[stored_count] = lvl;
                    stored_count++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            CMD_PROBE: begin
                for (int i = 0; i < stored_count; i++) begin
                    if (stored_keys[i] == key) begin
                        a = longint'(lvl);
                        b = longint'(stored_levels[i]);
                        add += (a >= b) ? a - b : b - a;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    add = longint'(lvl);
                total = longint'(running_sum) + add;
                if (total > longint'(32'hFFFF_FFFF)) begin
                    total       = longint'(32'hFFFF_FFFF);
                    sum_clipped = 1'b1;
                end
                running_sum = total[AccW-1:0];
                if (last) begin
                    res.distance     = running_sum;
                    res.saturated    = sum_clipped;
                    res.ref_overflow = drop_seen;
                    pending_sums     = {pending_sums, res};
                    running_sum = '0;
                    sum_clipped = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // result checker, values sampled before the edge
    always @(posedge i_clk) begin
        t_dist_result exp_res;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result distance %0h", o_distance));
            end else begin
                exp_res = pending_sums.pop_front();
                if (o_distance !== exp_res.distance)
                    report_mismatch($sformatf("distance got %0h want %0h",
                                              o_distance, exp_res.distance));
                if (o_saturated !== exp_res.saturated)
                    report_mismatch($sformatf("saturated got %b want %b",
                                              o_saturated, exp_res.saturated));
                if (o_ref_overflow !== exp_res.ref_overflow)
                    report_mismatch($sformatf("ref_overflow got %b want %b",
                                              o_ref_overflow, exp_res.ref_overflow));
            end
        end
    end

    task automatic issue_request(input logic [1:0] cmd,
                                 input logic [KeyBits-1:0] key,
                                 input logic [LevelBits-1:0] lvl,
                                 input logic last);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_room_key <= key;
        i_level    <= lvl;
        i_last     <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_request(cmd, key, lvl, last);
    endtask

    // hold off the next request until every result is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [LevelBits-1:0] pick_level();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return LevelBits'($urandom);
    endfunction

    task automatic test_empty_store();
        idle_pct = 0;
        issue_request(CMD_PROBE, '0, '1, 1'b1);
        issue_request(CMD_PROBE, '1, '0, 1'b0);
        issue_request(CMD_PROBE, 8'h3C, 16'h1234, 1'b1);
    endtask

    task automatic test_matching();
        idle_pct = 0;
        issue_request(CMD_CLEAR, 8'hA5, 16'hBEEF, 1'b1);
        issue_request(CMD_APPEND, '1, '0, 1'b0);
        issue_request(CMD_APPEND, '1, '1, 1'b1);       // last ignored on append
        issue_request(CMD_APPEND, '0, 16'h8000, 1'b0);
        issue_request(CMD_APPEND, '0, 16'h8000, 1'b0); // duplicate entry
        issue_request(CMD_APPEND, 8'h5A, 16'h0100, 1'b0);
        issue_request(CMD_PROBE, '1, 16'h4000, 1'b0);
        issue_request(CMD_PROBE, '0, 16'h0001, 1'b0);  // below stored level
        issue_request(CMD_PROBE, '0, '1, 1'b0);        // above stored level
        issue_request(CMD_PROBE, 8'h77, 16'h0042, 1'b1); // no key match
        issue_request(CmdUnused, 8'h5A, '1, 1'b1);     // ignored command
        issue_request(CMD_PROBE, 8'h5A, 16'h0100, 1'b1);
        issue_request(CMD_CLEAR, '0, '0, 1'b1);
        issue_request(CMD_PROBE, '1, 16'h0007, 1'b1);
    endtask

    task automatic test_drop_flag();
        idle_pct = 0;
        issue_request(CMD_CLEAR, '0, '0, 1'b0);
        for (int i = 0; i <= MaxRefEntries; i++)
            issue_request(CMD_APPEND, KeyBits'(i), LevelBits'(i * 16'h0F0F), 1'b0);
        issue_request(CMD_PROBE, 8'h10, 16'h2222, 1'b1);
        // flag survives the emit
        issue_request(CMD_PROBE, 8'h03, 16'h0000, 1'b1);
        issue_request(CMD_CLEAR, '0, '0, 1'b0);
        issue_request(CMD_APPEND, 8'h03, 16'h0300, 1'b0);
        issue_request(CMD_PROBE, 8'h03, 16'h0000, 1'b1);
    endtask

    task automatic test_saturation();
        idle_pct = 0;
        issue_request(CMD_CLEAR, '0, '0, 1'b0);
        for (int i = 0; i < MaxRefEntries; i++)
            issue_request(CMD_APPEND, 8'h5A, '0, 1'b1);
        // every probe hits all cells with the widest difference
        for (int i = 0; i < 4100; i++)
            issue_request(CMD_PROBE, 8'h5A, '1, 1'b0);
        issue_request(CMD_CLEAR, '0, '0, 1'b0);
        issue_request(CMD_PROBE, 8'h01, 16'h0005, 1'b1);
        // flag and sum gone after the emit
        issue_request(CMD_PROBE, 8'h01, 16'h0009, 1'b1);
    endtask

    task automatic test_random(input int pct, input int n_items);
        logic [KeyBits-1:0] key_pool [4];
        int                 sent;
        int                 n_app;
        int                 n_probe;
        int                 n_lists;
        logic [KeyBits-1:0] key;
        idle_pct = pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                foreach (key_pool[k])
                    key_pool[k] = KeyBits'($urandom);
                if ($urandom_range(3) != 0) begin
                    issue_request(CMD_CLEAR, KeyBits'($urandom), pick_level(),
                                  1'($urandom));
                    sent++;
                end
                n_app = $urandom_range(MaxRefEntries + 2);
                for (int i = 0; i < n_app; i++) begin
                    issue_request(CMD_APPEND, key_pool[$urandom_range(3)], pick_level(),
                                  1'($urandom));
                    sent++;
                end
                n_lists = $urandom_range(1, 3);
                for (int l = 0; l < n_lists; l++) begin
                    n_probe = $urandom_range(1, 6);
                    for (int p = 0; p < n_probe; p++) begin
                        key = ($urandom_range(3) == 0) ? KeyBits'($urandom)
                                                       : key_pool[$urandom_range(3)];
                        issue_request(CMD_PROBE, key, pick_level(), p == n_probe - 1);
                        sent++;
                    end
                end
            end else begin
                // noise: any command, any last
                issue_request(2'($urandom_range(3)), KeyBits'($urandom), pick_level(),
                              1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= CMD_CLEAR;
        i_room_key <= '0;
        i_level    <= '0;
        i_last     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_matching();
        test_drop_flag();
        wait_drained();
        test_saturation();
        wait_drained();
        test_random(29, 170);
        wait_drained();
        test_random(64, 170);
        test_random(0, 170);

        wait_drained();
        repeat (DrainWait) @(posedge i_clk);
        if (err_count == 0 && pending_sums.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (pending_sums.size() != 0)
                report_mismatch($sformatf("%0d results never came", pending_sums.size()));
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
